// ===== hdl/tcbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcbg_pkg
// Shared widths, register indexes and elaboration-time helpers for the
// tone curve pipeline (log2 table entries, exp2 step constants).
// ----------------------------------------------------------------------------
package tcbg_pkg;

  localparam int FRAC       = 30;         // fraction bits of the fixed-point values
  localparam int LEVELS_DEF = 256;
  localparam int LEVEL_W    = 8;          // level_in / level_out width
  localparam int LOG_W      = 35;         // log2 value, Q.30
  localparam int T_W        = 41;         // d*100 and the exponent t
  localparam int N_W        = T_W - FRAC; // integer part of t
  localparam int G_W        = 9;
  localparam int G_MIN      = 30;
  localparam int G_MAX      = 300;
  localparam int P_W        = FRAC + 1;   // 2^-t, Q.30, at most 1.0
  localparam int Y_W        = 47;         // maxv * q
  localparam int K_W        = 8;          // 100+k and 100-k
  localparam int PROD_W     = 55;         // |y-h| * (100+k)
  localparam int X_W        = 58;         // signed curve value
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_GAMMA      = 2'd2
  } cfg_reg_e;

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x, res, b;
    x   = x_in;
    res = '0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2 of v in Q.30 by repeated squaring
  function automatic logic [63:0] log2_q30(input logic [31:0] v);
    int p;
    logic [63:0] m, fr;
    p  = 0;
    fr = '0;
    while (p < 16 && (v >> (p + 1)) != 0) p++;
    m = 64'(v) << (FRAC - p);
    for (int i = 1; i <= FRAC; i++) begin
      m = (m * m) >> FRAC;
      if (m >= (64'd1 << (FRAC + 1))) begin
        m  = m >> 1;
        fr = fr | (64'd1 << (FRAC - i));
      end
    end
    return (64'(p) << FRAC) | fr;
  endfunction

  // 2^(-2^-i) in Q.30, each from the one before by a square root
  function automatic logic [63:0] exp_const(input int i);
    logic [63:0] s;
    s = (64'd1 << FRAC) >> 1;
    for (int j = 1; j <= i; j++) s = isqrt64(s << FRAC);
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tcbg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcbg_div
// Pipelined unsigned restoring divider: one quotient bit per stage, with a
// side payload and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module tcbg_div #(
  parameter int NW = 41,
  parameter int DW = 9,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic      [NW-1:0] quo_o,
  output logic      [SW-1:0] side_o
);

  logic          vld_q  [NW+1];
  logic [DW-1:0] rem_q  [NW+1];
  logic [NW-1:0] nq_q   [NW+1];
  logic [DW-1:0] den_q  [NW+1];
  logic [SW-1:0] side_q [NW+1];

  assign vld_q[0]  = vld_i;
  assign rem_q[0]  = '0;
  assign nq_q[0]   = num_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_q[j], nq_q[j][NW-1]};
    assign ge    = trial >= {1'b0, den_q[j]};
    assign diff  = trial - {1'b0, den_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_q[j+1]   <= {nq_q[j][NW-2:0], ge};
        den_q[j+1]  <= den_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign vld_o  = vld_q[NW];
  assign quo_o  = nq_q[NW];
  assign side_o = side_q[NW];

endmodule
`default_nettype wire

// ===== hdl/tcbg_exp2.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcbg_exp2
// Pipelined 2^-f for a Q.30 fraction: one stage per fraction bit, each
// multiplying by the matching 2^(-2^-i) constant when the bit is set.
// ----------------------------------------------------------------------------
module tcbg_exp2
  import tcbg_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire logic [FRAC-1:0] frac_i,
  input  wire logic [N_W-1:0] int_i,
  input  wire logic           zero_i,
  output logic                vld_o,
  output logic     [P_W-1:0]  prod_o,
  output logic     [N_W-1:0]  int_o,
  output logic                zero_o
);

  logic            vld_q  [FRAC+1];
  logic [P_W-1:0]  p_q    [FRAC+1];
  logic [FRAC-1:0] f_q    [FRAC+1];
  logic [N_W-1:0]  n_q    [FRAC+1];
  logic            zero_q [FRAC+1];

  assign vld_q[0]  = vld_i;
  assign p_q[0]    = P_W'(64'd1 << FRAC);
  assign f_q[0]    = frac_i;
  assign n_q[0]    = int_i;
  assign zero_q[0] = zero_i;

  for (genvar i = 0; i < FRAC; i++) begin : g_stage
    localparam logic [63:0] SC = exp_const(i + 1);
    logic [P_W+FRAC-1:0] mult;

    // conditional multiply by this step's constant, truncated
    assign mult = p_q[i] * SC[FRAC-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[i+1]    <= f_q[i][FRAC-1-i] ? mult[P_W+FRAC-1:FRAC] : p_q[i];
        f_q[i+1]    <= f_q[i];
        n_q[i+1]    <= n_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  assign vld_o  = vld_q[FRAC];
  assign prod_o = p_q[FRAC];
  assign int_o  = n_q[FRAC];
  assign zero_o = zero_q[FRAC];

endmodule
`default_nettype wire

// ===== hdl/tone_curve_brightness_contrast_gamma.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_curve_brightness_contrast_gamma
// Gamma, contrast and brightness tone curve on a stream of pixel levels.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid / tready            tdata[7:0] level_in
//  m_axis    out  tvalid / tready            tdata[7:0] level_out
//  cfg       in   cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One word per cycle while m_axis takes words. On its way to m_axis a word
// passes the two bit-per-stage dividers (41 and 55 stages), the 30-stage
// exp2 product chain, the single stages 1 to 8 and the output register.
// The whole pipeline advances together; when the output word is not taken it
// moves to a skid register, and the pipeline freezes while that is full, so
// s_axis_tready comes straight from a register.
// Reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module tone_curve_brightness_contrast_gamma
  import tcbg_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] level_in
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [7:0]            m_axis_tdata,   // [7:0] level_out
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [16:0]    MAXV    = 17'(LEVELS - 1);
  localparam logic [63:0]    LOG_MAX = log2_q30(32'(LEVELS - 1));
  localparam logic [Y_W-1:0] HALF    = Y_W'(MAXV) << (FRAC - 1);
  localparam logic [X_W-1:0] TOP     = X_W'(MAXV) << FRAC;

  // configuration registers
  logic [6:0]     bright_q, contrast_q;
  logic [G_W-1:0] gamma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= '0;
      contrast_q <= '0;
      gamma_q    <= G_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BRIGHTNESS: bright_q   <= cfg_data_i[6:0];
        REG_CONTRAST:   contrast_q <= cfg_data_i[6:0];
        REG_GAMMA:      gamma_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [K_W-1:0] k_s;
  logic [K_W-1:0]        k_num, k_den;
  logic [G_W-1:0]        g_clamp;

  assign k_s     = {contrast_q[6], contrast_q};
  assign k_num   = K_W'(100) + k_s;
  assign k_den   = K_W'(100) - k_s;
  assign g_clamp = (gamma_q < G_W'(G_MIN)) ? G_W'(G_MIN) :
                   (gamma_q > G_W'(G_MAX)) ? G_W'(G_MAX) : gamma_q;

  // log2 table for every 8-bit level
  logic [LOG_W-1:0] log_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_log
    localparam logic [63:0] LV = log2_q30(32'(gi));
    assign log_tab[gi] = LV[LOG_W-1:0];
  end

  logic en;
  logic out_vld_q;
  logic [7:0] out_q;
  logic skid_vld_q, skid_vld_d;
  logic [7:0] skid_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // stage 1: clamp level
  logic       v1_vld_q;
  logic [7:0] v1_q;
  logic [7:0] v_clamp;

  assign v_clamp = ({9'd0, s_axis_tdata} > MAXV) ? MAXV[7:0] : s_axis_tdata;

  // stage 2: log distance
  logic             d2_vld_q, z2_q;
  logic [LOG_W-1:0] d2_q;
  logic [LOG_W-1:0] lv;

  assign lv = log_tab[v1_q];

  // stage 3: scale by 100
  logic           n3_vld_q, z3_q;
  logic [T_W-1:0] n3_q;
  logic [G_W-1:0] g3_q;

  // stage 4: shift by integer part
  logic           q4_vld_q;
  logic [P_W-1:0] q4_q;

  // stage 5: scale to levels
  logic           y5_vld_q;
  logic [Y_W-1:0] y5_q;

  // stage 6: offset from mid scale
  logic           m6_vld_q, neg6_q;
  logic [Y_W-1:0] m6_q;

  // stage 7: contrast numerator
  logic              p7_vld_q, neg7_q;
  logic [PROD_W-1:0] p7_q;
  logic [K_W-1:0]    kd7_q;

  // stage 8: signed curve value
  logic           x8_vld_q;
  logic [X_W-1:0] x8_q;

  // divider and exp2 outputs
  logic           t_vld, t_zero;
  logic [T_W-1:0] t_quo;
  logic [0:0]     t_side;
  logic           e_vld, e_zero;
  logic [P_W-1:0] e_prod;
  logic [N_W-1:0] e_int;
  logic              c_vld;
  logic [PROD_W-1:0] c_quo;
  logic [0:0]        c_side;

  assign t_zero = t_side[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_vld_q  <= 1'b0;
      d2_vld_q  <= 1'b0;
      n3_vld_q  <= 1'b0;
      q4_vld_q  <= 1'b0;
      y5_vld_q  <= 1'b0;
      m6_vld_q  <= 1'b0;
      p7_vld_q  <= 1'b0;
      x8_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_vld_q  <= s_axis_tvalid;
      d2_vld_q  <= v1_vld_q;
      n3_vld_q  <= d2_vld_q;
      q4_vld_q  <= e_vld;
      y5_vld_q  <= q4_vld_q;
      m6_vld_q  <= y5_vld_q;
      p7_vld_q  <= m6_vld_q;
      x8_vld_q  <= c_vld;
      out_vld_q <= x8_vld_q;
    end
  end

  logic [Y_W-1:0]    y_next;
  logic [PROD_W-1:0] p_next;
  logic [X_W-1:0]    q_signed, b_term, x_next;

  assign y_next   = Y_W'(MAXV[15:0]) * Y_W'(q4_q);
  assign p_next   = PROD_W'(m6_q) * PROD_W'(k_num);
  assign q_signed = c_side[0] ? -(X_W'(c_quo)) : X_W'(c_quo);
  assign b_term   = (X_W'(signed'(bright_q)) << (FRAC + 1)) + (X_W'(1) << (FRAC - 1));
  assign x_next   = q_signed + X_W'(HALF) + b_term;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_q  <= v_clamp;
      z2_q  <= (v1_q == 8'd0);
      d2_q  <= (LOG_MAX[LOG_W-1:0] > lv) ? LOG_MAX[LOG_W-1:0] - lv : '0;
      n3_q  <= T_W'(d2_q) * T_W'(100);
      g3_q  <= g_clamp;
      z3_q  <= z2_q;
      q4_q  <= (e_zero || e_int >= N_W'(63)) ? '0 : P_W'(e_prod >> e_int);
      y5_q  <= y_next;
      neg6_q <= y5_q < HALF;
      m6_q  <= (y5_q < HALF) ? HALF - y5_q : y5_q - HALF;
      neg7_q <= neg6_q;
      p7_q  <= p_next;
      kd7_q <= k_den;
      x8_q  <= x_next;
    end
  end

  // exponent t = d*100/g
  tcbg_div #(.NW(T_W), .DW(G_W), .SW(1)) u_div_gamma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (n3_vld_q),
    .num_i  (n3_q),
    .den_i  (g3_q),
    .side_i (z3_q),
    .vld_o  (t_vld),
    .quo_o  (t_quo),
    .side_o (t_side)
  );

  tcbg_exp2 u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (t_vld),
    .frac_i (t_quo[FRAC-1:0]),
    .int_i  (t_quo[T_W-1:FRAC]),
    .zero_i (t_zero),
    .vld_o  (e_vld),
    .prod_o (e_prod),
    .int_o  (e_int),
    .zero_o (e_zero)
  );

  // contrast divide, magnitude only, sign rides along
  tcbg_div #(.NW(PROD_W), .DW(K_W), .SW(1)) u_div_contrast (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p7_vld_q),
    .num_i  (p7_q),
    .den_i  (kd7_q),
    .side_i (neg7_q),
    .vld_o  (c_vld),
    .quo_o  (c_quo),
    .side_o (c_side)
  );

  // saturate into the output register
  logic [X_W-1:0] sat;
  assign sat = x8_q[X_W-1] ? '0 :
               (signed'(x8_q) > signed'(TOP)) ? X_W'(MAXV) : (x8_q >> FRAC);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= sat[7:0];
    end
  end

  // skid register: catches the output word when it is not taken
  assign skid_vld_d = skid_vld_q ? !m_axis_tready : (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_q <= out_q;
    end
  end

  assign m_axis_tvalid = skid_vld_q || out_vld_q;
  assign m_axis_tdata  = skid_vld_q ? skid_q : out_q;

endmodule
`default_nettype wire
